// ----- rtl/csic_pkg.sv -----
`default_nettype none

package csic_pkg;

  localparam int unsigned NPiece      = 7;
  localparam int unsigned NOrientDig  = 6;
  localparam int unsigned NPermCell   = 6;
  localparam int unsigned NCell       = 12;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned IndexW      = 22;
  localparam int unsigned PermW       = 21;
  localparam int unsigned OrientW     = 14;
  localparam logic [IndexW-1:0] IndexLimit = 22'd3674160;

  typedef enum logic {
    FuncEncode = 1'b0,
    FuncDecode = 1'b1
  } csic_func_e;

  typedef struct packed {
    logic               func;
    logic [PermW-1:0]   perm_in;
    logic [OrientW-1:0] orient_in;
    logic [IndexW-1:0]  index_in;
  } csic_in_t;

  typedef struct packed {
    logic [IndexW-1:0]  index_out;
    logic [PermW-1:0]   perm_out;
    logic [OrientW-1:0] orient_out;
    logic               bad_index;
  } csic_out_t;

  // Working item that travels down the cell chain.
  typedef struct packed {
    csic_func_e        func;
    logic              bad;
    logic [IndexW-1:0] acc;
    logic [6:0][2:0]   perm;
    logic [6:0][2:0]   inv;
    logic [5:0][1:0]   orient;
    logic [1:0]        omod;
  } csic_cell_t;

  // Place value of each cell's digit in the mixed-radix index. The first six
  // cells carry permutation digits for k = 6 down to 1 (weight 729 * k!), the
  // last six carry the base-3 orientation digits of pieces 0 to 5.
  function automatic logic [21:0] csic_weight(input logic [SlotW-1:0] slot);
    logic [21:0] w;
    unique case (slot)
      4'd0:    w = 22'd524880;
      4'd1:    w = 22'd87480;
      4'd2:    w = 22'd17496;
      4'd3:    w = 22'd4374;
      4'd4:    w = 22'd1458;
      4'd5:    w = 22'd729;
      4'd6:    w = 22'd243;
      4'd7:    w = 22'd81;
      4'd8:    w = 22'd27;
      4'd9:    w = 22'd9;
      4'd10:   w = 22'd3;
      4'd11:   w = 22'd1;
      default: w = 22'd1;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] csic_max_digit(input logic [SlotW-1:0] slot);
    logic [2:0] m;
    unique case (slot)
      4'd0:    m = 3'd6;
      4'd1:    m = 3'd5;
      4'd2:    m = 3'd4;
      4'd3:    m = 3'd3;
      4'd4:    m = 3'd2;
      4'd5:    m = 3'd1;
      default: m = 3'd2;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/csic_load.sv -----
`default_nettype none

module csic_load (
  input  csic_pkg::csic_in_t   item_i,
  output csic_pkg::csic_cell_t cell_o
);

  always_comb begin
    logic [6:0] found;
    logic [2:0] pos;
    logic [1:0] dig;
    cell_o = '0;
    found  = '0;
    pos    = '0;
    dig    = '0;
    if (item_i.func == csic_pkg::FuncEncode) begin
      cell_o.func = csic_pkg::FuncEncode;
      cell_o.acc  = '0;
      for (int k = 0; k < csic_pkg::NPiece; k++) begin
        pos = item_i.perm_in[3*k +: 3];
        cell_o.perm[k] = pos;
        for (int v = 0; v < csic_pkg::NPiece; v++) begin
          if (pos == 3'(v)) begin
            found[v]     = 1'b1;
            cell_o.inv[v] = 3'(k);
          end
        end
      end
      // Any position of 7 or any repeat leaves a hole in the found mask.
      cell_o.bad = ~&found;
      for (int k = 0; k < csic_pkg::NOrientDig; k++) begin
        dig = item_i.orient_in[2*k +: 2];
        cell_o.orient[k] = (dig == 2'd3) ? 2'd0 : dig;
      end
    end else begin
      cell_o.func = csic_pkg::FuncDecode;
      cell_o.acc  = item_i.index_in;
      cell_o.bad  = (item_i.index_in >= csic_pkg::IndexLimit);
      for (int k = 0; k < csic_pkg::NPiece; k++) begin
        cell_o.perm[k] = 3'(k);
        cell_o.inv[k]  = 3'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csic_cell.sv -----
`default_nettype none

module csic_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           slot_i,
  input  logic                 valid_i,
  input  csic_pkg::csic_cell_t cell_i,
  output logic                 valid_o,
  output csic_pkg::csic_cell_t cell_o
);

  logic                 valid_q;
  csic_pkg::csic_cell_t cell_d, cell_q;

  always_comb begin
    logic [21:0] w;
    logic [21:0] cand;
    logic [21:0] acc_dec;
    logic [2:0]  m;
    logic [2:0]  pk;
    logic [2:0]  oj;
    logic [2:0]  dig;
    logic [2:0]  jpos;
    logic [2:0]  msum;
    logic        is_perm;
    w       = csic_pkg::csic_weight(slot_i);
    m       = csic_pkg::csic_max_digit(slot_i);
    is_perm = (slot_i < 4'(csic_pkg::NPermCell));
    pk      = 3'(4'(csic_pkg::NPiece - 1) - slot_i);
    oj      = 3'(slot_i - 4'(csic_pkg::NPermCell));
    cell_d  = cell_i;
    jpos    = '0;
    msum    = '0;
    cand    = '0;

    // Decode: largest digit whose multiple of the weight still fits.
    dig     = '0;
    acc_dec = cell_i.acc;
    for (int s = 1; s < csic_pkg::NPiece; s++) begin
      cand = 22'(s) * w;
      if ((3'(s) <= m) && (cell_i.acc >= cand)) begin
        dig     = 3'(s);
        acc_dec = cell_i.acc - cand;
      end
    end

    if (!cell_i.bad) begin
      if (cell_i.func == csic_pkg::FuncEncode) begin
        if (is_perm) begin
          // Move value k into place k, keeping the inverse table in step.
          dig  = cell_i.perm[pk];
          jpos = cell_i.inv[pk];
          cell_d.perm[pk]  = cell_i.perm[jpos];
          cell_d.perm[jpos] = dig;
          cell_d.inv[pk]   = cell_i.inv[dig];
          cell_d.inv[dig]  = jpos;
        end else begin
          dig = {1'b0, cell_i.orient[oj]};
        end
        cell_d.acc = cell_i.acc + 22'(dig) * w;
      end else begin
        cell_d.acc = acc_dec;
        if (is_perm) begin
          cell_d.perm[pk]  = cell_i.perm[dig];
          cell_d.perm[dig] = cell_i.perm[pk];
        end else begin
          cell_d.orient[oj] = dig[1:0];
          msum = 3'(cell_i.omod) + dig;
          cell_d.omod = (msum >= 3'd3) ? 2'(msum - 3'd3) : msum[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

`default_nettype wire

// ----- rtl/csic_pack.sv -----
`default_nettype none

module csic_pack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  csic_pkg::csic_cell_t cell_i,
  output logic                 done_o,
  output csic_pkg::csic_out_t  result_o
);

  logic                done_q;
  csic_pkg::csic_out_t result_d, result_q;

  always_comb begin
    logic       is_enc;
    logic [1:0] last;
    is_enc = (cell_i.func == csic_pkg::FuncEncode);
    // The seventh orientation brings the sum back to zero mod 3.
    case (cell_i.omod)
      2'd1:    last = 2'd2;
      2'd2:    last = 2'd1;
      default: last = 2'd0;
    endcase
    result_d.bad_index  = cell_i.bad;
    result_d.index_out  = (is_enc && !cell_i.bad) ? cell_i.acc : '0;
    result_d.perm_out   = (!is_enc && !cell_i.bad) ? cell_i.perm : '0;
    result_d.orient_out = (!is_enc && !cell_i.bad) ? {last, cell_i.orient} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ----- rtl/cube_state_index_codec.sv -----
`default_nettype none

// Channel   Handshake          Payload
// -------   ----------------   ------------------------------------------
// request   start_i / busy_o   item_i   (func, perm_in, orient_in, index_in)
// result    done_o (strobe)    result_o (index_out, perm_out, orient_out,
//                                        bad_index)
//
// One item is accepted per clock cycle; busy_o never rises.
// The accepting edge loads the first of thirteen registers (twelve digit
// cells and the output register); an item passes through them in order and
// its result is then shown on result_o.
// Reset clears only the valid bits of the cells and the done strobe.
// The receiver cannot stall; done_o pulses for exactly one cycle per item.

module cube_state_index_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  csic_pkg::csic_in_t  item_i,
  output logic                done_o,
  output csic_pkg::csic_out_t result_o
);

  // The index is one mixed-radix number: six permutation digits with weights
  // 729 * k! (k = 6 down to 1) followed by six base-3 orientation digits.
  // Each cell owns one digit. On encode it adds digit times weight to the
  // running index; on decode it peels off its digit by comparing against the
  // multiples of its weight and subtracting. The permutation cells also swap
  // entries of the carried permutation, and on encode of the inverse table.

  logic                 chain_valid [csic_pkg::NCell+1];
  csic_pkg::csic_cell_t chain_data  [csic_pkg::NCell+1];

  // The block is fully pipelined, so it never pushes back.
  assign busy_o = 1'b0;

  assign chain_valid[0] = start_i && !busy_o;

  csic_load u_load (
    .item_i (item_i),
    .cell_o (chain_data[0])
  );

  for (genvar g = 0; g < csic_pkg::NCell; g++) begin : g_cell
    csic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .slot_i  (4'(g)),
      .valid_i (chain_valid[g]),
      .cell_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .cell_o  (chain_data[g+1])
    );
  end

  csic_pack u_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (chain_valid[csic_pkg::NCell]),
    .cell_i   (chain_data[csic_pkg::NCell]),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb_cube_state_index_codec.sv -----
`default_nettype none

// Self-checking bench for the 2x2 cube state index codec.
//
// Items are driven on start_i / item_i in bursts of random length with random
// idle gaps. A monitor notes every accepted item in a scoreboard, which
// computes the expected result from its own copy of the ranking rules. Every
// done_o strobe is checked field by field against the oldest expected result.
// The block keeps no state, so each item's result depends only on that item.

module tb_cube_state_index_codec;

  // Number of orientation codes (3^6) and the permutation digit weights k!.
  localparam int unsigned OrientCodes = 729;
  localparam int unsigned Fact [7] = '{1, 1, 2, 6, 24, 120, 720};

  localparam int unsigned NumRandomItems = 1850;
  // The drain wait is far longer than the pipeline is deep, so a stray
  // result has time to show up before the verdict.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;

  // Scoreboard: keeps the expected results in acceptance order and checks
  // every result strobe against the oldest one.
  class codec_scoreboard;
    csic_pkg::csic_out_t expected_results[$];
    int unsigned err_cnt;

    function new();
      err_cnt = 0;
    endfunction

    // Ranks a state into an index (encode) or unranks an index into a
    // state (decode).
    function csic_pkg::csic_out_t index_codec_result(csic_pkg::csic_in_t it);
      csic_pkg::csic_out_t r;
      logic [2:0] p [7];
      logic [2:0] inv [7];
      logic [2:0] t;
      logic [6:0] seen;
      bit ok;
      int unsigned rank, code, d, s, j, x, y, sum;
      r = '0;
      if (it.func == csic_pkg::FuncEncode) begin
        ok = 1'b1;
        seen = '0;
        for (int k = 0; k < 7; k++) begin
          p[k] = it.perm_in[3*k +: 3];
          if (p[k] == 3'd7) begin
            ok = 1'b0;
          end else begin
            seen[p[k]] = 1'b1;
            inv[p[k]] = 3'(k);
          end
        end
        if (seen != 7'h7F) ok = 1'b0;
        // Orientations of pieces 0..5 in base 3, piece 0 most significant.
        // A digit of 3 counts as 0 and the seventh piece is not encoded.
        code = 0;
        for (int k = 0; k < 6; k++) begin
          d = 32'(it.orient_in[2*k +: 2]);
          if (d == 3) d = 0;
          code = code * 3 + d;
        end
        if (ok) begin
          // Swap ranking: move value k into place k, from the top down.
          rank = 0;
          for (int k = 6; k > 0; k--) begin
            s = 32'(p[k]);
            j = 32'(inv[k]);
            t = p[k]; p[k] = p[j]; p[j] = t;
            t = inv[k]; inv[k] = inv[s]; inv[s] = t;
            rank += s * Fact[k];
          end
          r.index_out = 22'(rank * OrientCodes + code);
        end else begin
          r.bad_index = 1'b1;
        end
      end else begin
        if (it.index_in >= csic_pkg::IndexLimit) begin
          r.bad_index = 1'b1;
        end else begin
          x = 32'(it.index_in) / OrientCodes;
          y = 32'(it.index_in) % OrientCodes;
          for (int k = 0; k < 7; k++) p[k] = 3'(k);
          for (int k = 6; k > 0; k--) begin
            s = x / Fact[k];
            x = x % Fact[k];
            if (s > k) s = k;
            t = p[k]; p[k] = p[s]; p[s] = t;
          end
          for (int k = 0; k < 7; k++) r.perm_out[3*k +: 3] = p[k];
          // Least significant base-3 digit belongs to piece 5.
          sum = 0;
          for (int k = 0; k < 6; k++) begin
            d = y % 3;
            y = y / 3;
            sum += d;
            r.orient_out[2*(5-k) +: 2] = 2'(d);
          end
          // The seventh orientation makes the total a multiple of 3.
          r.orient_out[13:12] = 2'((3 - sum % 3) % 3);
        end
      end
      return r;
    endfunction

    function void note_item(csic_pkg::csic_in_t it);
      expected_results.insert(expected_results.size(), index_codec_result(it));
    endfunction

    function void check_result(csic_pkg::csic_out_t got);
      csic_pkg::csic_out_t exp_r;
      if (expected_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ReportLimit)
          $display("result with nothing expected: index %0d perm %h orient %h bad %0b",
                   got.index_out, got.perm_out, got.orient_out, got.bad_index);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.index_out !== exp_r.index_out || got.perm_out !== exp_r.perm_out ||
          got.orient_out !== exp_r.orient_out || got.bad_index !== exp_r.bad_index) begin
        err_cnt++;
        if (err_cnt <= ReportLimit)
          $display("mismatch: index %0d/%0d perm %h/%h orient %h/%h bad %0b/%0b (exp/got)",
                   exp_r.index_out, got.index_out, exp_r.perm_out, got.perm_out,
                   exp_r.orient_out, got.orient_out, exp_r.bad_index, got.bad_index);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  csic_pkg::csic_in_t  item_i;
  logic                done_o;
  csic_pkg::csic_out_t result_o;

  codec_scoreboard board = new();
  int unsigned cycle_cnt = 0;

  cube_state_index_codec uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog. A correct run ends far below this limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("** cube_state_index_codec: FAILED **");
      $finish;
    end
  end

  // Monitor. Inputs are driven by nonblocking assignments at the rising edge,
  // so here the handshake signals still show the values of the cycle that
  // this edge ends. An item is taken when start_i is high and busy_o is low;
  // a result is taken on every done_o strobe since it cannot be held off.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start_i && !busy_o) board.note_item(item_i);
      if (done_o) board.check_result(result_o);
    end
  end

  function automatic csic_pkg::csic_in_t build_item(csic_pkg::csic_func_e func,
                                                    logic [20:0] perm,
                                                    logic [13:0] orient,
                                                    logic [21:0] idx);
    csic_pkg::csic_in_t it;
    it.func = func;
    it.perm_in = perm;
    it.orient_in = orient;
    it.index_in = idx;
    return it;
  endfunction

  // Random item. Most encodes carry a real permutation since only those reach
  // the ranking network; some carry one corrupted entry or raw bits to hit
  // the invalid permutation path. Most decodes carry an in-range index, the
  // rest raw bits that are sometimes out of range. Unused fields hold noise.
  function automatic csic_pkg::csic_in_t random_item();
    csic_pkg::csic_in_t it;
    logic [2:0] order [7];
    logic [2:0] t;
    int unsigned pick, j;
    it.func = csic_pkg::FuncEncode;
    it.perm_in = 21'($urandom);
    it.orient_in = 14'($urandom);
    it.index_in = 22'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 46) begin
      for (int k = 0; k < 7; k++) order[k] = 3'(k);
      for (int k = 6; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k]; order[k] = order[j]; order[j] = t;
      end
      for (int k = 0; k < 7; k++) it.perm_in[3*k +: 3] = order[k];
      // One entry rewritten at random: usually a duplicate, sometimes the value 7.
      if (pick >= 42) it.perm_in[3*$urandom_range(0, 6) +: 3] = 3'($urandom);
    end else if (pick < 50) begin
      it.func = csic_pkg::FuncEncode;
    end else if (pick < 94) begin
      it.func = csic_pkg::FuncDecode;
      it.index_in = 22'($urandom_range(0, csic_pkg::IndexLimit - 1));
    end else begin
      it.func = csic_pkg::FuncDecode;
    end
    return it;
  endfunction

  // Presents one item and returns at the edge that accepts it. start_i stays
  // high, so a following call continues the burst without a bubble.
  task automatic send_item(csic_pkg::csic_in_t it);
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Idles the request side with noise on the payload.
  task automatic idle_for(int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      item_i <= random_item();
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stops sending until every expected result has come back.
  task automatic hold_until_drained();
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent, burst_len, gap;
    bit held;

    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: identity and reversed permutations, all orientation
    // digit values including the digit 3 that counts as 0, the ignored
    // seventh orientation, invalid permutations (value 7, duplicates), and
    // decode indexes at zero, at the orientation boundary, at the last valid
    // index and beyond it. Some items carry all ones in their unused fields to
    // show they are ignored.
    send_item(build_item(csic_pkg::FuncEncode, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
                         14'h0000, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
                         14'h3FFF, 22'h3FFFFF));
    send_item(build_item(csic_pkg::FuncEncode, {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
                         14'h0AAA, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
                         14'h2AAA, 22'h3FFFFF));
    send_item(build_item(csic_pkg::FuncEncode, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
                         14'h1555, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, {3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1},
                         14'h2D1B, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, {3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0},
                         14'h1E27, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, 21'h1FFFFF, 14'h3FFF, 22'h3FFFFF));
    send_item(build_item(csic_pkg::FuncEncode, 21'h000000, 14'h0000, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, {3'd6, 3'd5, 3'd4, 3'd7, 3'd2, 3'd1, 3'd0},
                         14'h0AAA, 22'h000000));
    send_item(build_item(csic_pkg::FuncEncode, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
                         14'h0555, 22'h000000));
    send_item(build_item(csic_pkg::FuncDecode, 21'h000000, 14'h0000, 22'd0));
    send_item(build_item(csic_pkg::FuncDecode, 21'h1FFFFF, 14'h3FFF, 22'd1));
    send_item(build_item(csic_pkg::FuncDecode, 21'h000000, 14'h0000, 22'd728));
    send_item(build_item(csic_pkg::FuncDecode, 21'h000000, 14'h0000, 22'd729));
    send_item(build_item(csic_pkg::FuncDecode, 21'h1FFFFF, 14'h3FFF,
                         csic_pkg::IndexLimit - 22'd1));
    send_item(build_item(csic_pkg::FuncDecode, 21'h000000, 14'h0000,
                         csic_pkg::IndexLimit));
    send_item(build_item(csic_pkg::FuncDecode, 21'h1FFFFF, 14'h3FFF, 22'h3FFFFF));
    send_item(build_item(csic_pkg::FuncDecode, 21'h000000, 14'h0000, 22'h2AAAAA));
    send_item(build_item(csic_pkg::FuncDecode, 21'h000000, 14'h0000, 22'h155555));
    hold_until_drained();

    // Random part in bursts. Some gaps are zero, which joins bursts into
    // long stretches at full rate; once, midway, the sender waits for the
    // pipeline to empty completely.
    sent = 0;
    held = 1'b0;
    while (sent < NumRandomItems) begin
      burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 12);
      for (int n = 0; n < burst_len && sent < NumRandomItems; n++) begin
        send_item(random_item());
        sent++;
      end
      if (!held && sent >= NumRandomItems / 2) begin
        held = 1'b1;
        hold_until_drained();
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
        idle_for(gap);
      end
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (board.err_cnt == 0 && board.pending() == 0) begin
      $display("** cube_state_index_codec: PASSED **");
    end else begin
      $display("** cube_state_index_codec: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/csic_pkg.sv
rtl/csic_load.sv
rtl/csic_cell.sv
rtl/csic_pack.sv
rtl/cube_state_index_codec.sv
verif/tb_cube_state_index_codec.sv
